### sv/stramp_pkg.sv
// Shared types, constants and codes for the trapezoidal step ramp generator.
`timescale 1ns / 1ps

package stramp_pkg;

   localparam int MOTOR_LINES     = 8;
   localparam int STEP_COUNT_BITS = 24;

   localparam int SPEED_W  = 19;
   localparam int RAMP_W   = 16;
   localparam int LOAD_W   = 14;
   localparam int PERIOD_W = 20;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 19;

   localparam int DIV_W     = 19;
   localparam int DIV_STEPS = DIV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [DIV_W-1:0]    TICK_CLOCK = DIV_W'(400000);
   localparam logic [LOAD_W-1:0]   TIMER_SPAN = LOAD_W'(10000);
   localparam logic [LOAD_W-1:0]   RAMP_TOP   = LOAD_W'(1000);
   localparam logic [SPEED_W-1:0]  SLOW_HZ    = SPEED_W'(40);
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
   localparam logic [PERIOD_W-1:0] PERIOD_START = PERIOD_W'(1000 * 256);

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEPS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MASK = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_MASK = 2'd3;

   typedef struct packed {
      logic                       mode;
      logic [STEP_COUNT_BITS-1:0] move_steps;
   } req_type;

   typedef struct packed {
      logic                       reload_valid;
      logic [LOAD_W-1:0]          timer_start_count;
      logic [MOTOR_LINES-1:0]     pulse_drive;
      logic [MOTOR_LINES-1:0]     pulse_check;
      logic                       moving;
      logic [STEP_COUNT_BITS-1:0] steps_remaining;
   } rsp_type;

   typedef struct packed {
      logic take_item;
      logic min_slow;
      logic div_go_speed;
      logic div_go_ramp;
      logic load_min;
      logic zero_step;
      logic load_step;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic speed_slow;
      logic ramp_zero;
      logic min_ge_top;
      logic div_done;
   } sts_type;

endpackage

### sv/stramp_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module stramp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       go,
   input  logic [stramp_pkg::DIV_W-1:0] dividend,
   input  logic [stramp_pkg::DIV_W-1:0] divisor,
   output logic                       done,
   output logic [stramp_pkg::DIV_W-1:0] quotient
);
   import stramp_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, dvs_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/stramp_ctrl.sv
// Controller state machine: item handshake and the start-time division sequence.
`timescale 1ns / 1ps

module stramp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_ready,
   input  stramp_pkg::sts_type sts,
   output stramp_pkg::cmd_type cmd
);
   import stramp_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SETUP   = 3'd1;
   localparam logic [2:0] S_DIV_SPD = 3'd2;
   localparam logic [2:0] S_CHECK   = 3'd3;
   localparam logic [2:0] S_DIV_RMP = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && sts.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.take_item = 1'b1;
               if (req_mode == MODE_START) begin
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            if (sts.speed_slow) begin
               cmd.min_slow = 1'b1;
               state_in     = S_CHECK;
            end else begin
               cmd.div_go_speed = 1'b1;
               state_in         = S_DIV_SPD;
            end
         end
         S_DIV_SPD: begin
            if (sts.div_done) begin
               cmd.load_min = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.ramp_zero) begin
               state_in = S_IDLE;
            end else if (sts.min_ge_top) begin
               cmd.zero_step = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.div_go_ramp = 1'b1;
               state_in        = S_DIV_RMP;
            end
         end
         S_DIV_RMP: begin
            if (sts.div_done) begin
               cmd.load_step = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Items are only taken from the idle state.
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == S_IDLE)
      else $error("item accepted outside idle");

   // A start item blocks the next item while its divisions run.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_mode == MODE_START) |=> !req_ready)
      else $error("ready after start item");

   // A finished speed division always leads to the ramp check.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_SPD && sts.div_done) |=> state_ff == S_CHECK)
      else $error("speed division result lost");

   // The ramp division never starts while the minimum period is at or above the ramp top.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_go_ramp |-> (!sts.min_ge_top && !sts.ramp_zero))
      else $error("ramp division started without a ramp");

endmodule

### sv/stramp_dpath.sv
// Datapath: registers, move state, tick arithmetic, divider and result register.
`timescale 1ns / 1ps

module stramp_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  stramp_pkg::cmd_type                 cmd,
   output stramp_pkg::sts_type                 sts,
   input  stramp_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output stramp_pkg::rsp_type                 rsp_data,
   input  logic                                csr_valid,
   input  logic [stramp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stramp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                                csr_ready
);
   import stramp_pkg::*;

   localparam int CW = STEP_COUNT_BITS;

   logic [SPEED_W-1:0]     max_speed_ff;
   logic [RAMP_W-1:0]      ramp_steps_ff;
   logic [MOTOR_LINES-1:0] drive_mask_ff;
   logic [MOTOR_LINES-1:0] check_mask_ff;

   logic [CW-1:0]          accel_ff, accel_in;
   logic [CW-1:0]          cruise_ff, cruise_in;
   logic [CW-1:0]          decel_ff, decel_in;
   logic [CW-1:0]          total_ff, total_in;
   logic [PERIOD_W-1:0]    period_fixed_ff, period_fixed_in;
   logic [PERIOD_W-1:0]    period_step_ff, period_step_in;
   logic [LOAD_W-1:0]      min_period_ff, min_period_in;
   logic                   half_ff, half_in;
   logic [MOTOR_LINES-1:0] held_drive_ff, held_drive_in;
   logic [MOTOR_LINES-1:0] held_check_ff, held_check_in;
   logic [SPEED_W-1:0]     op_speed_ff;
   logic [RAMP_W-1:0]      op_ramp_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   div_go;
   logic [DIV_W-1:0]       div_dividend;
   logic [DIV_W-1:0]       div_divisor;
   logic                   div_done;
   logic [DIV_W-1:0]       div_quotient;

   logic [LOAD_W-1:0]      ramp_load;
   logic [LOAD_W-1:0]      ramp_diff;
   logic [RAMP_W:0]        twice_ramp;
   logic                   stepped;
   logic                   high;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= SPEED_W'(4000);
         ramp_steps_ff <= RAMP_W'(100);
         drive_mask_ff <= MOTOR_LINES'(1);
         check_mask_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAX_SPEED:  max_speed_ff  <= csr_wdata[SPEED_W-1:0];
            CSR_RAMP_STEPS: ramp_steps_ff <= csr_wdata[RAMP_W-1:0];
            CSR_DRIVE_MASK: drive_mask_ff <= csr_wdata[MOTOR_LINES-1:0];
            CSR_CHECK_MASK: check_mask_ff <= csr_wdata[MOTOR_LINES-1:0];
            default: ;
         endcase
      end
   end

   assign ramp_load  = TIMER_SPAN - LOAD_W'(period_fixed_ff[PERIOD_W-1:8]);
   assign ramp_diff  = RAMP_TOP - min_period_ff;
   assign twice_ramp = {ramp_steps_ff, 1'b0};
   assign high       = half_ff;

   assign div_go       = cmd.div_go_speed || cmd.div_go_ramp;
   assign div_dividend = cmd.div_go_ramp ? DIV_W'({ramp_diff[9:0], 8'b0}) : TICK_CLOCK;
   assign div_divisor  = cmd.div_go_ramp ? DIV_W'(op_ramp_ff) : DIV_W'(op_speed_ff);

   stramp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      accel_in        = accel_ff;
      cruise_in       = cruise_ff;
      decel_in        = decel_ff;
      total_in        = total_ff;
      period_fixed_in = period_fixed_ff;
      period_step_in  = period_step_ff;
      min_period_in   = min_period_ff;
      half_in         = half_ff;
      held_drive_in   = held_drive_ff;
      held_check_in   = held_check_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      stepped         = 1'b0;

      if (cmd.take_item) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (req_data.mode == MODE_START) begin
            if (req_data.move_steps < CW'(twice_ramp)) begin
               accel_in  = {1'b0, req_data.move_steps[CW-1:1]};
               decel_in  = req_data.move_steps - {1'b0, req_data.move_steps[CW-1:1]};
               cruise_in = '0;
            end else begin
               accel_in  = CW'(ramp_steps_ff);
               decel_in  = CW'(ramp_steps_ff);
               cruise_in = req_data.move_steps - CW'(twice_ramp);
            end
            period_fixed_in     = PERIOD_START;
            total_in            = req_data.move_steps;
            held_drive_in       = drive_mask_ff;
            held_check_in       = check_mask_ff;
            rsp_in.reload_valid = 1'b1;
         end else begin
            if (accel_ff != '0) begin
               rsp_in.reload_valid      = 1'b1;
               rsp_in.timer_start_count = ramp_load;
               if (high) begin
                  accel_in        = accel_ff - 1'b1;
                  period_fixed_in = (period_fixed_ff > period_step_ff) ?
                                    period_fixed_ff - period_step_ff : '0;
                  stepped         = 1'b1;
               end
            end else if (cruise_ff != '0) begin
               rsp_in.reload_valid      = 1'b1;
               rsp_in.timer_start_count = TIMER_SPAN - min_period_ff;
               if (high) begin
                  cruise_in = cruise_ff - 1'b1;
                  stepped   = 1'b1;
               end
            end else if (decel_ff != '0) begin
               rsp_in.reload_valid      = 1'b1;
               rsp_in.timer_start_count = ramp_load;
               if (high) begin
                  decel_in        = decel_ff - 1'b1;
                  period_fixed_in = (period_step_ff > PERIOD_MAX - period_fixed_ff) ?
                                    PERIOD_MAX : period_fixed_ff + period_step_ff;
                  stepped         = 1'b1;
               end
            end
            if (stepped) begin
               if (total_ff != '0) begin
                  total_in = total_ff - 1'b1;
               end
               rsp_in.pulse_drive = held_drive_ff;
               rsp_in.pulse_check = held_check_ff;
            end
            half_in = !high;
         end
         rsp_in.moving          = (total_in != '0);
         rsp_in.steps_remaining = total_in;
      end

      if (cmd.min_slow) begin
         min_period_in = TIMER_SPAN;
      end else if (cmd.load_min) begin
         min_period_in = div_quotient[LOAD_W-1:0];
      end
      if (cmd.zero_step) begin
         period_step_in = '0;
      end else if (cmd.load_step) begin
         period_step_in = PERIOD_W'(div_quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff        <= '0;
         cruise_ff       <= '0;
         decel_ff        <= '0;
         total_ff        <= '0;
         period_fixed_ff <= '0;
         period_step_ff  <= '0;
         min_period_ff   <= '0;
         half_ff         <= 1'b0;
         held_drive_ff   <= '0;
         held_check_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         accel_ff        <= accel_in;
         cruise_ff       <= cruise_in;
         decel_ff        <= decel_in;
         total_ff        <= total_in;
         period_fixed_ff <= period_fixed_in;
         period_step_ff  <= period_step_in;
         min_period_ff   <= min_period_in;
         half_ff         <= half_in;
         held_drive_ff   <= held_drive_in;
         held_check_ff   <= held_check_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (cmd.take_item && req_data.mode == MODE_START) begin
         op_speed_ff <= max_speed_ff;
         op_ramp_ff  <= ramp_steps_ff;
      end
   end

   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.speed_slow = op_speed_ff < SLOW_HZ;
   assign sts.ramp_zero  = (op_ramp_ff == '0);
   assign sts.min_ge_top = min_period_ff >= RAMP_TOP;
   assign sts.div_done   = div_done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/stepper_trapezoid_ramp.sv
// Top level of the trapezoidal step ramp generator: controller plus datapath.
//
//   Channel  Ports                          Direction  Carries
//   req      req_valid/req_ready/req_data   in         start or tick item
//   rsp      rsp_valid/rsp_ready/rsp_data   out        one result item per input item
//   csr      csr_valid/csr_ready/csr_index  in         register write, data on csr_wdata
//
// A tick item's result is registered at the same edge that takes the item.
// A start item returns its result at once, then the block takes no item while one
// shared bit-serial divider computes the cruise period and then the ramp period delta,
// 19 iterations each; a slow speed or a missing ramp skips one or both.
// Reset is synchronous and clears all move state.
// A waiting result blocks the next item only until rsp_ready takes it.
`timescale 1ns / 1ps

module stepper_trapezoid_ramp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  stramp_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output stramp_pkg::rsp_type               rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stramp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stramp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import stramp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   stramp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   stramp_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready)
   );

endmodule
